FILE: rtl/iprt_pkg.sv
package iprt_pkg;

	localparam int unsigned TABLE_DEPTH = 16;
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] next_hop;
		logic [7:0]  metric;
		logic [3:0]  port;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic             init;
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             out_en;
	} cmd_t;

endpackage

FILE: rtl/iprt_ctrl.sv
module iprt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	output logic          busy,
	output iprt_pkg::cmd_t cmd
);

	iprt_pkg::state_t state_q, state_d;
	logic [iprt_pkg::IDX_W-1:0] cnt_q, cnt_d;
	logic accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iprt_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		busy       = 1'b1;
		cmd.wr_en  = 1'b0;
		cmd.init   = 1'b0;
		cmd.rd_en  = 1'b0;
		cmd.rd_idx = cnt_q;
		cmd.out_en = 1'b0;
		unique case (state_q)
			iprt_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (req_type == iprt_pkg::REQ_LOOKUP) begin
						cmd.init = 1'b1;
						cnt_d    = '0;
						state_d  = iprt_pkg::ST_SCAN;
					end else begin
						cmd.wr_en = 1'b1;
					end
				end
			end
			iprt_pkg::ST_SCAN: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == iprt_pkg::LAST_IDX) begin
					state_d = iprt_pkg::ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			iprt_pkg::ST_DRAIN: begin
				state_d = iprt_pkg::ST_DONE;
			end
			iprt_pkg::ST_DONE: begin
				cmd.out_en = 1'b1;
				state_d    = iprt_pkg::ST_IDLE;
			end
			default: begin
				state_d = iprt_pkg::ST_IDLE;
			end
		endcase
	end

	a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == iprt_pkg::REQ_LOOKUP |=>
			state_q == iprt_pkg::ST_SCAN && cnt_q == '0)
		else $error("lookup transfer did not start a scan at entry zero");

	a_scan_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iprt_pkg::ST_SCAN && cnt_q != iprt_pkg::LAST_IDX |=>
			state_q == iprt_pkg::ST_SCAN && cnt_q == $past(cnt_q) + 1'b1)
		else $error("scan skipped or repeated an entry");

	a_drain_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == iprt_pkg::ST_SCAN && cnt_q == iprt_pkg::LAST_IDX |=>
			state_q == iprt_pkg::ST_DRAIN ##1 cmd.out_en)
		else $error("result not strobed after the last entry");

endmodule

FILE: rtl/iprt_dp.sv
module iprt_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  iprt_pkg::cmd_t cmd,
	input  logic [3:0]     entry_slot,
	input  logic [31:0]    new_dest,
	input  logic [31:0]    new_mask,
	input  logic [31:0]    new_next_hop,
	input  logic [7:0]     new_metric,
	input  logic [3:0]     new_port,
	input  logic [31:0]    lookup_address,
	output logic           found,
	output logic [31:0]    route_dest,
	output logic [31:0]    route_next_hop,
	output logic [3:0]     route_port
);

	iprt_pkg::entry_t entry_q [iprt_pkg::TABLE_DEPTH];
	logic [iprt_pkg::TABLE_DEPTH-1:0] valid_q;

	iprt_pkg::entry_t rd_s1;
	logic valid_s1;
	logic cmp_en_s1;

	logic [31:0] addr_q;
	logic have_q;
	iprt_pkg::entry_t best_q;

	logic wr_hit;
	logic [iprt_pkg::IDX_W-1:0] wr_idx;
	iprt_pkg::entry_t wr_entry;
	logic match;
	logic better;

	assign wr_hit = cmd.wr_en && (32'(entry_slot) < iprt_pkg::TABLE_DEPTH);
	assign wr_idx = iprt_pkg::IDX_W'(entry_slot);

	always_comb begin
		wr_entry.dest     = new_dest;
		wr_entry.mask     = new_mask;
		wr_entry.next_hop = new_next_hop;
		wr_entry.metric   = new_metric;
		wr_entry.port     = new_port;
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			entry_q[wr_idx] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_s1 <= entry_q[cmd.rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			valid_s1  <= 1'b0;
			cmp_en_s1 <= 1'b0;
		end else begin
			if (wr_hit) begin
				valid_q[wr_idx] <= 1'b1;
			end
			cmp_en_s1 <= cmd.rd_en;
			if (cmd.rd_en) begin
				valid_s1 <= valid_q[cmd.rd_idx];
			end
		end
	end

	assign match = cmp_en_s1 && valid_s1 && ((addr_q & rd_s1.mask) == rd_s1.dest);
	assign better = !have_q || (rd_s1.metric < best_q.metric) ||
		((rd_s1.metric == best_q.metric) && (rd_s1.mask > best_q.mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (cmd.init) begin
			have_q <= 1'b0;
		end else if (match) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			addr_q <= lookup_address;
		end
		if (match && better) begin
			best_q <= rd_s1;
		end
	end

	assign found          = have_q;
	assign route_dest     = have_q ? best_q.dest : '0;
	assign route_next_hop = have_q ? best_q.next_hop : '0;
	assign route_port     = have_q ? best_q.port : '0;

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_hit |=> valid_q[$past(wr_idx)])
		else $error("route write did not mark its slot valid");

	a_match_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		match && !cmd.init |=> have_q)
		else $error("matching entry lost");

endmodule

FILE: rtl/ipv4_route_table_lookup.sv
// ipv4 route table lookup
// command channel: an item is taken at a rising edge with start high and busy low.
// req_type selects a route write (entry_slot, new_* fields) or a lookup
// (lookup_address); the fields of the other kind are ignored.
// a write returns nothing; busy stays low, so another item may follow in the
// next cycle. a write to a slot beyond the table is dropped.
// a lookup scans the table one entry a cycle through a single read port:
// busy rises after the transfer; after the scan state and the drain state, done pulses
// for one cycle with found, route_dest, route_next_hop and route_port; busy is
// still high in that cycle and falls at the edge that ends it, so no new item is
// taken until a lookup is through.
// on a match the smallest metric wins, then the larger mask, then the lower slot;
// with no match found is low and the route fields are zero.
// the result holds until the next lookup is taken; the receiver cannot stall done.
// reset clears all valid bits and returns the controller to idle.
module ipv4_route_table_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [3:0]  entry_slot,
	input  logic [31:0] new_dest,
	input  logic [31:0] new_mask,
	input  logic [31:0] new_next_hop,
	input  logic [7:0]  new_metric,
	input  logic [3:0]  new_port,
	input  logic [31:0] lookup_address,
	output logic        done,
	output logic        found,
	output logic [31:0] route_dest,
	output logic [31:0] route_next_hop,
	output logic [3:0]  route_port
);

	iprt_pkg::cmd_t cmd;

	iprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.busy     (busy),
		.cmd      (cmd)
	);

	iprt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.entry_slot     (entry_slot),
		.new_dest       (new_dest),
		.new_mask       (new_mask),
		.new_next_hop   (new_next_hop),
		.new_metric     (new_metric),
		.new_port       (new_port),
		.lookup_address (lookup_address),
		.found          (found),
		.route_dest     (route_dest),
		.route_next_hop (route_next_hop),
		.route_port     (route_port)
	);

	assign done = cmd.out_en;

endmodule
